FILE: rtl/adm_pkg.sv
`default_nettype none

package adm_pkg;

  // Default vertex capacity of the block.
  localparam int unsigned ADM_MAX_VERTICES = 16;

  // Field widths of the channels.
  localparam int unsigned OP_W       = 3;
  localparam int unsigned VIDX_W     = 4;
  localparam int unsigned LBL_W      = 8;
  localparam int unsigned VCNT_W     = 5;
  localparam int unsigned VIDX_LIMIT = 16;

  // One traversal produces at most this many visits.
  localparam int unsigned MAX_RESULTS = 16;
  localparam int unsigned NVIS_W      = $clog2(MAX_RESULTS + 1);

  localparam logic [VCNT_W-1:0] VCOUNT_RESET = VCNT_W'(16);

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_SET_LABEL     = 3'd0,
    OP_ADD_EDGE      = 3'd1,
    OP_CLEAR_GRAPH   = 3'd2,
    OP_CLEAR_VISITED = 3'd3,
    OP_TRAVERSE      = 3'd4
  } adm_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EDGE_A,
    ST_EDGE_B,
    ST_RESP,
    ST_VISIT,
    ST_SCAN,
    ST_POP,
    ST_FLUSH
  } adm_state_e;

  // Requests from the controller to the graph store.
  typedef struct packed {
    logic adj_re;
    logic adj_we;
    logic lbl_re;
    logic lbl_we;
    logic clear_adj;
  } gs_ctrl_t;

  // Requests from the controller to the frame stack.
  typedef struct packed {
    logic re;
    logic we;
  } stk_ctrl_t;

  // Number of vertices that can actually be stored: capped by the index width.
  function automatic int unsigned adm_used(input int unsigned max_v);
    int unsigned r;
    r = (max_v < VIDX_LIMIT) ? max_v : VIDX_LIMIT;
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/adm_in_if.sv
`default_nettype none

interface adm_in_if;
  import adm_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [VIDX_W-1:0] vertex_a;
  logic [VIDX_W-1:0] vertex_b;
  logic [LBL_W-1:0]  label;

  modport source (output valid, output operation, output vertex_a, output vertex_b,
                  output label, input ready);
  modport sink (input valid, input operation, input vertex_a, input vertex_b,
                input label, output ready);
endinterface

`default_nettype wire

FILE: rtl/adm_out_if.sv
`default_nettype none

interface adm_out_if;
  import adm_pkg::*;

  logic              valid;
  logic              ready;
  logic [VIDX_W-1:0] visit_index;
  logic [LBL_W-1:0]  visit_label;
  logic              status;
  logic              last;

  modport source (output valid, output visit_index, output visit_label, output status,
                  output last, input ready);
  modport sink (input valid, input visit_index, input visit_label, input status,
                input last, output ready);
endinterface

`default_nettype wire

FILE: rtl/adm_cfg_if.sv
`default_nettype none

interface adm_cfg_if;
  import adm_pkg::*;

  logic              valid;
  logic              ready;
  logic [VCNT_W-1:0] vertex_count;

  modport source (output valid, output vertex_count, input ready);
  modport sink (input valid, input vertex_count, output ready);
endinterface

`default_nettype wire

FILE: rtl/adm_graph_store.sv
`default_nettype none

module adm_graph_store #(
  parameter int unsigned MAX_VERTICES = adm_pkg::ADM_MAX_VERTICES,
  localparam int unsigned NV = adm_pkg::adm_used(MAX_VERTICES),
  localparam int unsigned IW = $clog2(NV)
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire adm_pkg::gs_ctrl_t       ctrl_i,
  input  wire logic [IW-1:0]           adj_raddr_i,
  input  wire logic [IW-1:0]           adj_waddr_i,
  input  wire logic [NV-1:0]           adj_wdata_i,
  input  wire logic [IW-1:0]           lbl_raddr_i,
  input  wire logic [IW-1:0]           lbl_waddr_i,
  input  wire logic [adm_pkg::LBL_W-1:0] lbl_wdata_i,
  output logic [NV-1:0]                adj_rdata_o,
  output logic [adm_pkg::LBL_W-1:0]    lbl_rdata_o
);
  import adm_pkg::*;

  logic [NV-1:0]    adj_mem [NV];
  logic [LBL_W-1:0] lbl_mem [NV];

  // A row or label that was never written since reset (or since a graph clear,
  // for rows) reads as zero.
  logic [NV-1:0]    adj_vld_q;
  logic [NV-1:0]    lbl_vld_q;
  logic [NV-1:0]    adj_rd_q;
  logic             adj_rv_q;
  logic [LBL_W-1:0] lbl_rd_q;
  logic             lbl_rv_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.adj_we) begin
      adj_mem[adj_waddr_i] <= adj_wdata_i;
    end
    if (ctrl_i.lbl_we) begin
      lbl_mem[lbl_waddr_i] <= lbl_wdata_i;
    end
    if (ctrl_i.adj_re) begin
      adj_rd_q <= adj_mem[adj_raddr_i];
      adj_rv_q <= adj_vld_q[adj_raddr_i];
    end
    if (ctrl_i.lbl_re) begin
      lbl_rd_q <= lbl_mem[lbl_raddr_i];
      lbl_rv_q <= lbl_vld_q[lbl_raddr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      adj_vld_q <= '0;
      lbl_vld_q <= '0;
    end else begin
      if (ctrl_i.clear_adj) begin
        adj_vld_q <= '0;
      end else if (ctrl_i.adj_we) begin
        adj_vld_q[adj_waddr_i] <= 1'b1;
      end
      if (ctrl_i.lbl_we) begin
        lbl_vld_q[lbl_waddr_i] <= 1'b1;
      end
    end
  end

  assign adj_rdata_o = adj_rv_q ? adj_rd_q : '0;
  assign lbl_rdata_o = lbl_rv_q ? lbl_rd_q : '0;

endmodule

`default_nettype wire

FILE: rtl/adm_frame_stack.sv
`default_nettype none

module adm_frame_stack #(
  parameter int unsigned MAX_VERTICES = adm_pkg::ADM_MAX_VERTICES,
  localparam int unsigned NV = adm_pkg::adm_used(MAX_VERTICES),
  localparam int unsigned IW = $clog2(NV),
  localparam int unsigned PW = $clog2(NV + 1),
  localparam int unsigned FW = IW + PW + NV
) (
  input  wire logic               clk_i,
  input  wire adm_pkg::stk_ctrl_t ctrl_i,
  input  wire logic [IW-1:0]      waddr_i,
  input  wire logic [FW-1:0]      wdata_i,
  input  wire logic [IW-1:0]      raddr_i,
  output logic [FW-1:0]           rdata_o
);
  import adm_pkg::*;

  // Each entry holds a suspended frame: vertex, resume position and its row.
  logic [FW-1:0] mem [NV];
  logic [FW-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.we) begin
      mem[waddr_i] <= wdata_i;
    end
    if (ctrl_i.re) begin
      rd_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rd_q;

endmodule

`default_nettype wire

FILE: rtl/adm_ctrl.sv
`default_nettype none

module adm_ctrl #(
  parameter int unsigned MAX_VERTICES = adm_pkg::ADM_MAX_VERTICES,
  localparam int unsigned NV = adm_pkg::adm_used(MAX_VERTICES),
  localparam int unsigned IW = $clog2(NV),
  localparam int unsigned PW = $clog2(NV + 1),
  localparam int unsigned FW = IW + PW + NV
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  adm_in_if.sink                         in_i,
  adm_out_if.source                      out_o,
  adm_cfg_if.sink                        cfg_i,
  output adm_pkg::gs_ctrl_t              gs_ctrl_o,
  output logic [IW-1:0]                  adj_raddr_o,
  output logic [IW-1:0]                  adj_waddr_o,
  output logic [NV-1:0]                  adj_wdata_o,
  output logic [IW-1:0]                  lbl_raddr_o,
  output logic [IW-1:0]                  lbl_waddr_o,
  output logic [adm_pkg::LBL_W-1:0]      lbl_wdata_o,
  input  wire logic [NV-1:0]             adj_rdata_i,
  input  wire logic [adm_pkg::LBL_W-1:0] lbl_rdata_i,
  output adm_pkg::stk_ctrl_t             stk_ctrl_o,
  output logic [IW-1:0]                  stk_waddr_o,
  output logic [FW-1:0]                  stk_wdata_o,
  output logic [IW-1:0]                  stk_raddr_o,
  input  wire logic [FW-1:0]             stk_rdata_i
);
  import adm_pkg::*;

  adm_state_e state_q, state_d;

  logic [VCNT_W-1:0] vcount_q;
  logic [VCNT_W-1:0] cnt;
  logic [NV-1:0]     visited_q, visited_d;
  logic [PW-1:0]     depth_q, depth_d;
  logic [PW-1:0]     depth_m1, depth_m2;
  logic [NVIS_W-1:0] nvis_q, nvis_d;

  logic [IW-1:0]     va_q, va_d, vb_q, vb_d;
  logic              resp_status_q, resp_status_d;
  logic [IW-1:0]     top_v_q, top_v_d;
  logic [PW-1:0]     top_pos_q, top_pos_d;
  logic [NV-1:0]     top_row_q, top_row_d;

  logic              pend_vld_q, pend_vld_d;
  logic [IW-1:0]     pend_idx_q, pend_idx_d;
  logic [LBL_W-1:0]  pend_lbl_q, pend_lbl_d;

  logic              out_vld_q, out_vld_d;
  logic [VIDX_W-1:0] out_idx_q;
  logic [LBL_W-1:0]  out_lbl_q;
  logic              out_status_q;
  logic              out_last_q;
  logic              out_free;
  logic              out_ld;
  logic [VIDX_W-1:0] ld_idx;
  logic [LBL_W-1:0]  ld_lbl;
  logic              ld_status;
  logic              ld_last;

  logic              accept;
  logic [IW-1:0]     va_in, vb_in;
  logic              va_bad, vb_bad;
  logic [NV-1:0]     cand;
  logic              found;
  logic [IW-1:0]     j_sel;
  logic              can_push;

  // Effective vertex count, clamped to one up to the storage size.
  always_comb begin
    if (vcount_q == '0) begin
      cnt = VCNT_W'(1);
    end else if (vcount_q > VCNT_W'(NV)) begin
      cnt = VCNT_W'(NV);
    end else begin
      cnt = vcount_q;
    end
  end

  assign accept   = in_i.valid && in_i.ready;
  assign va_in    = in_i.vertex_a[IW-1:0];
  assign vb_in    = in_i.vertex_b[IW-1:0];
  assign va_bad   = {1'b0, in_i.vertex_a} >= cnt;
  assign vb_bad   = {1'b0, in_i.vertex_b} >= cnt;
  assign depth_m1 = depth_q - PW'(1);
  assign depth_m2 = depth_q - PW'(2);
  assign out_free = !out_vld_q || out_o.ready;

  // Neighbors of the top frame that are adjacent, unvisited, in range and
  // at or past the frame's resume position; the lowest one is taken next.
  always_comb begin
    for (int i = 0; i < NV; i++) begin
      cand[i] = top_row_q[i] && !visited_q[i] && (PW'(i) >= top_pos_q) &&
                (VCNT_W'(i) < cnt);
    end
    j_sel = '0;
    for (int i = NV - 1; i >= 0; i--) begin
      if (cand[i]) begin
        j_sel = IW'(i);
      end
    end
  end

  assign found    = |cand;
  assign can_push = found && (nvis_q < NVIS_W'(MAX_RESULTS)) && (depth_q < PW'(NV));

  always_comb begin
    state_d       = state_q;
    visited_d     = visited_q;
    depth_d       = depth_q;
    nvis_d        = nvis_q;
    va_d          = va_q;
    vb_d          = vb_q;
    resp_status_d = resp_status_q;
    top_v_d       = top_v_q;
    top_pos_d     = top_pos_q;
    top_row_d     = top_row_q;
    pend_vld_d    = pend_vld_q;
    pend_idx_d    = pend_idx_q;
    pend_lbl_d    = pend_lbl_q;
    gs_ctrl_o     = '0;
    stk_ctrl_o    = '0;
    adj_raddr_o   = '0;
    adj_waddr_o   = '0;
    adj_wdata_o   = '0;
    lbl_raddr_o   = '0;
    lbl_waddr_o   = '0;
    lbl_wdata_o   = '0;
    stk_waddr_o   = '0;
    stk_wdata_o   = '0;
    stk_raddr_o   = '0;
    out_ld        = 1'b0;
    ld_idx        = '0;
    ld_lbl        = '0;
    ld_status     = STATUS_OK;
    ld_last       = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          va_d          = va_in;
          vb_d          = vb_in;
          resp_status_d = STATUS_OK;
          unique case (adm_op_e'(in_i.operation))
            OP_SET_LABEL: begin
              state_d = ST_RESP;
              if (va_bad) begin
                resp_status_d = STATUS_RANGE;
              end else begin
                gs_ctrl_o.lbl_we = 1'b1;
                lbl_waddr_o      = va_in;
                lbl_wdata_o      = in_i.label;
              end
            end
            OP_ADD_EDGE: begin
              if (va_bad || vb_bad) begin
                resp_status_d = STATUS_RANGE;
                state_d       = ST_RESP;
              end else begin
                gs_ctrl_o.adj_re = 1'b1;
                adj_raddr_o      = va_in;
                state_d          = ST_EDGE_A;
              end
            end
            OP_CLEAR_GRAPH: begin
              gs_ctrl_o.clear_adj = 1'b1;
              visited_d           = '0;
              state_d             = ST_RESP;
            end
            OP_CLEAR_VISITED: begin
              visited_d = '0;
              state_d   = ST_RESP;
            end
            OP_TRAVERSE: begin
              if (va_bad) begin
                resp_status_d = STATUS_RANGE;
                state_d       = ST_RESP;
              end else begin
                visited_d        = visited_q | (NV'(1) << va_in);
                gs_ctrl_o.adj_re = 1'b1;
                gs_ctrl_o.lbl_re = 1'b1;
                adj_raddr_o      = va_in;
                lbl_raddr_o      = va_in;
                top_v_d          = va_in;
                depth_d          = PW'(1);
                nvis_d           = '0;
                state_d          = ST_VISIT;
              end
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end

      ST_EDGE_A: begin
        gs_ctrl_o.adj_we = 1'b1;
        adj_waddr_o      = va_q;
        adj_wdata_o      = adj_rdata_i | (NV'(1) << vb_q);
        gs_ctrl_o.adj_re = 1'b1;
        adj_raddr_o      = vb_q;
        state_d          = ST_EDGE_B;
      end

      ST_EDGE_B: begin
        // When both ends are the same vertex the old row is read back, which
        // rewrites the same value as the first write.
        gs_ctrl_o.adj_we = 1'b1;
        adj_waddr_o      = vb_q;
        adj_wdata_o      = adj_rdata_i | (NV'(1) << va_q);
        state_d          = ST_RESP;
      end

      ST_RESP: begin
        if (out_free) begin
          out_ld    = 1'b1;
          ld_status = resp_status_q;
          ld_last   = 1'b1;
          state_d   = ST_IDLE;
        end
      end

      ST_VISIT: begin
        if (!pend_vld_q || out_free) begin
          if (pend_vld_q) begin
            out_ld = 1'b1;
            ld_idx = VIDX_W'(pend_idx_q);
            ld_lbl = pend_lbl_q;
          end
          pend_vld_d = 1'b1;
          pend_idx_d = top_v_q;
          pend_lbl_d = lbl_rdata_i;
          nvis_d     = nvis_q + NVIS_W'(1);
          top_row_d  = adj_rdata_i;
          top_pos_d  = '0;
          state_d    = ST_SCAN;
        end
      end

      ST_SCAN: begin
        if (can_push) begin
          stk_ctrl_o.we    = 1'b1;
          stk_waddr_o      = depth_m1[IW-1:0];
          stk_wdata_o      = {top_v_q, PW'(j_sel) + PW'(1), top_row_q};
          visited_d        = visited_q | (NV'(1) << j_sel);
          top_v_d          = j_sel;
          depth_d          = depth_q + PW'(1);
          gs_ctrl_o.adj_re = 1'b1;
          gs_ctrl_o.lbl_re = 1'b1;
          adj_raddr_o      = j_sel;
          lbl_raddr_o      = j_sel;
          state_d          = ST_VISIT;
        end else begin
          depth_d = depth_m1;
          if (depth_q == PW'(1)) begin
            state_d = ST_FLUSH;
          end else begin
            stk_ctrl_o.re = 1'b1;
            stk_raddr_o   = depth_m2[IW-1:0];
            state_d       = ST_POP;
          end
        end
      end

      ST_POP: begin
        {top_v_d, top_pos_d, top_row_d} = stk_rdata_i;
        state_d                         = ST_SCAN;
      end

      ST_FLUSH: begin
        if (out_free) begin
          out_ld     = 1'b1;
          ld_idx     = VIDX_W'(pend_idx_q);
          ld_lbl     = pend_lbl_q;
          ld_last    = 1'b1;
          pend_vld_d = 1'b0;
          state_d    = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_vld_d = out_ld ? 1'b1 : (out_o.ready ? 1'b0 : out_vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      vcount_q   <= VCOUNT_RESET;
      visited_q  <= '0;
      depth_q    <= '0;
      nvis_q     <= '0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      visited_q  <= visited_d;
      depth_q    <= depth_d;
      nvis_q     <= nvis_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
      if (cfg_i.valid && cfg_i.ready) begin
        vcount_q <= cfg_i.vertex_count;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    va_q          <= va_d;
    vb_q          <= vb_d;
    resp_status_q <= resp_status_d;
    top_v_q       <= top_v_d;
    top_pos_q     <= top_pos_d;
    top_row_q     <= top_row_d;
    pend_idx_q    <= pend_idx_d;
    pend_lbl_q    <= pend_lbl_d;
    if (out_ld) begin
      out_idx_q    <= ld_idx;
      out_lbl_q    <= ld_lbl;
      out_status_q <= ld_status;
      out_last_q   <= ld_last;
    end
  end

  assign in_i.ready        = (state_q == ST_IDLE);
  assign cfg_i.ready       = 1'b1;
  assign out_o.valid       = out_vld_q;
  assign out_o.visit_index = out_idx_q;
  assign out_o.visit_label = out_lbl_q;
  assign out_o.status      = out_status_q;
  assign out_o.last        = out_last_q;

endmodule

`default_nettype wire

FILE: rtl/adjacency_matrix_dfs_top.sv
// Depth-first traversal engine over a small undirected graph.
//
// Channels: in_i takes command items (set label, add edge, clear graph, clear
// visited marks, traverse), out_o returns result items, and cfg_i writes the
// vertex count; all move an item when valid and ready are both high. cfg_i is
// always ready and must only be written while the block is idle.
// Every command except an unused operation code returns exactly one item with
// last set; a traversal returns one item per visited vertex in visit order,
// the final one with last. in_i is ready only while the controller is idle.
// A visit is a row/label read plus a scan, a backtrack is a scan plus a stack
// read; both wait on the registered reads of the memories. The next command
// can be taken once the last item of the one before is in the output register.
// A finished item waits in the output register; while out_o stalls, the
// controller holds as soon as it needs that register again.
// Reset empties the graph, zeroes labels and visited marks and sets the vertex
// count to 16; valid bits on rows and labels stand in for a clearing pass.
`default_nettype none

module adjacency_matrix_dfs_top #(
  parameter int unsigned MAX_VERTICES = adm_pkg::ADM_MAX_VERTICES
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  adm_in_if.sink    in_i,
  adm_out_if.source out_o,
  adm_cfg_if.sink   cfg_i
);
  import adm_pkg::*;

  // Storage size is capped by the 4-bit vertex index.
  localparam int unsigned NV = adm_used(MAX_VERTICES);
  localparam int unsigned IW = $clog2(NV);
  localparam int unsigned PW = $clog2(NV + 1);
  localparam int unsigned FW = IW + PW + NV;

  gs_ctrl_t         gs_ctrl;
  stk_ctrl_t        stk_ctrl;
  logic [IW-1:0]    adj_raddr;
  logic [IW-1:0]    adj_waddr;
  logic [NV-1:0]    adj_wdata;
  logic [IW-1:0]    lbl_raddr;
  logic [IW-1:0]    lbl_waddr;
  logic [LBL_W-1:0] lbl_wdata;
  logic [NV-1:0]    adj_rdata;
  logic [LBL_W-1:0] lbl_rdata;
  logic [IW-1:0]    stk_waddr;
  logic [FW-1:0]    stk_wdata;
  logic [IW-1:0]    stk_raddr;
  logic [FW-1:0]    stk_rdata;

  // The controller sequences every command, holds the visited marks, the top
  // stack frame and the output register.
  adm_ctrl #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .out_o       (out_o),
    .cfg_i       (cfg_i),
    .gs_ctrl_o   (gs_ctrl),
    .adj_raddr_o (adj_raddr),
    .adj_waddr_o (adj_waddr),
    .adj_wdata_o (adj_wdata),
    .lbl_raddr_o (lbl_raddr),
    .lbl_waddr_o (lbl_waddr),
    .lbl_wdata_o (lbl_wdata),
    .adj_rdata_i (adj_rdata),
    .lbl_rdata_i (lbl_rdata),
    .stk_ctrl_o  (stk_ctrl),
    .stk_waddr_o (stk_waddr),
    .stk_wdata_o (stk_wdata),
    .stk_raddr_o (stk_raddr),
    .stk_rdata_i (stk_rdata)
  );

  // Adjacency rows and vertex labels, each a synchronous memory with a registered read.
  adm_graph_store #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_graph_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (gs_ctrl),
    .adj_raddr_i (adj_raddr),
    .adj_waddr_i (adj_waddr),
    .adj_wdata_i (adj_wdata),
    .lbl_raddr_i (lbl_raddr),
    .lbl_waddr_i (lbl_waddr),
    .lbl_wdata_i (lbl_wdata),
    .adj_rdata_o (adj_rdata),
    .lbl_rdata_o (lbl_rdata)
  );

  // Suspended traversal frames below the top one.
  adm_frame_stack #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_frame_stack (
    .clk_i   (clk_i),
    .ctrl_i  (stk_ctrl),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  // An out-of-range status item is always the only item of its command.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.status == STATUS_RANGE) |-> out_o.last)
    else $error("range error item without last");

  // Adjacency writes only happen inside an add-edge sequence, never while
  // the block is open for a new command.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    gs_ctrl.adj_we |-> !in_i.ready)
    else $error("adjacency write while idle");

  // Clearing the graph only happens on the cycle its command is accepted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    gs_ctrl.clear_adj |-> in_i.valid && in_i.ready && !stk_ctrl.we)
    else $error("graph clear outside command acceptance");

  // The frame stack is never pushed and popped in the same cycle, and every push comes with an adjacency fetch.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stk_ctrl.we |-> !stk_ctrl.re && gs_ctrl.adj_re)
    else $error("frame push without adjacency fetch");

endmodule

`default_nettype wire

FILE: tb/testbench.sv
`default_nettype none

// Self-checking bench for the depth-first traversal engine.
//
// The bench keeps its own copy of the graph: adjacency rows, vertex labels,
// visited marks and the vertex count. Every command item accepted on the
// input channel is run through that copy, and the visits it must produce are
// queued. A checking process pops the oldest queued visit for every item the
// block hands out and compares it field by field.
module testbench;
  import adm_pkg::*;

  // Operation codes that the block does not implement; it must drop them.
  localparam logic [OP_W-1:0] OP_SPARE_LO  = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_MID = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_HI  = 3'd7;

  // Vertices that can really be addressed with the 4-bit index.
  localparam int unsigned VERTEX_CAP = (ADM_MAX_VERTICES < VIDX_LIMIT) ?
                                       ADM_MAX_VERTICES : VIDX_LIMIT;

  // Cycles to let pass after the last expected item before a register write
  // or the end of the run. Covers the unused codes, which give no item at
  // all.
  localparam int SETTLE_CYCLES  = 40;
  // Long output stall used to fill the block up.
  localparam int HOLD_CYCLES    = 300;
  // Cycles without any handshake before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 3000;

  typedef struct packed {
    logic [VIDX_W-1:0] idx;
    logic [LBL_W-1:0]  lbl;
    logic              status;
    logic              last;
  } visit_t;

  logic clk;
  logic rst_n;

  adm_in_if  in_if ();
  adm_out_if out_if ();
  adm_cfg_if cfg_if ();

  adjacency_matrix_dfs_top dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  // Clock with a period of 4 time units.
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Shadow copy of the block's graph state, updated as commands are accepted.
  logic [VIDX_LIMIT-1:0] graph_rows [VIDX_LIMIT];
  logic [LBL_W-1:0]      graph_labels [VIDX_LIMIT];
  logic [VIDX_LIMIT-1:0] seen_mask;
  logic [VCNT_W-1:0]     count_reg;

  // Visits still owed by the block, oldest first.
  visit_t expected_visits [$];

  // Idle rates in percent for the command side and the result side.
  int src_idle_pct;
  int snk_idle_pct;
  // A nonzero value asks the result side for a long stall of that length.
  int hold_request;

  int mismatches;
  int commands_sent;
  int traversals_sent;
  int visits_checked;
  int config_writes;
  int idle_cycles;

  // Number of vertices actually in use for a given register value: zero acts
  // as one, and anything above the capacity acts as the capacity.
  function automatic int limit_count(input logic [VCNT_W-1:0] value);
    int c;
    c = int'(value);
    if (c < 1) c = 1;
    if (c > int'(VERTEX_CAP)) c = int'(VERTEX_CAP);
    return c;
  endfunction

  function automatic visit_t make_visit(input int idx, input logic [LBL_W-1:0] lbl,
                                        input logic status, input logic last);
    visit_t item;
    item.idx    = VIDX_W'(idx);
    item.lbl    = lbl;
    item.status = status;
    item.last   = last;
    return item;
  endfunction

  // Works out what one command does to the graph and which visits it owes.
  task automatic predict_command(input logic [OP_W-1:0] op, input logic [VIDX_W-1:0] va,
                                 input logic [VIDX_W-1:0] vb, input logic [LBL_W-1:0] lab);
    int     cnt;
    int     n;
    int     depth;
    int     top;
    int     v;
    int     j;
    bit     found;
    int     frame_v [VIDX_LIMIT];
    int     frame_j [VIDX_LIMIT];
    visit_t trail [MAX_RESULTS];
    cnt = limit_count(count_reg);
    case (op)
      OP_SET_LABEL: begin
        if (int'(va) >= cnt) begin
          expected_visits.push_back(make_visit(0, '0, STATUS_RANGE, 1'b1));
        end else begin
          graph_labels[va] = lab;
          expected_visits.push_back(make_visit(0, '0, STATUS_OK, 1'b1));
        end
      end
      OP_ADD_EDGE: begin
        if (int'(va) >= cnt || int'(vb) >= cnt) begin
          expected_visits.push_back(make_visit(0, '0, STATUS_RANGE, 1'b1));
        end else begin
          graph_rows[va][vb] = 1'b1;
          graph_rows[vb][va] = 1'b1;
          expected_visits.push_back(make_visit(0, '0, STATUS_OK, 1'b1));
        end
      end
      OP_CLEAR_GRAPH: begin
        for (int r = 0; r < int'(VIDX_LIMIT); r++) graph_rows[r] = '0;
        seen_mask = '0;
        expected_visits.push_back(make_visit(0, '0, STATUS_OK, 1'b1));
      end
      OP_CLEAR_VISITED: begin
        seen_mask = '0;
        expected_visits.push_back(make_visit(0, '0, STATUS_OK, 1'b1));
      end
      OP_TRAVERSE: begin
        if (int'(va) >= cnt) begin
          expected_visits.push_back(make_visit(0, '0, STATUS_RANGE, 1'b1));
        end else begin
          // The start is always reported, visited or not.
          seen_mask[va] = 1'b1;
          trail[0] = make_visit(int'(va), graph_labels[va], STATUS_OK, 1'b0);
          n = 1;
          frame_v[0] = int'(va);
          frame_j[0] = 0;
          depth = 1;
          while (depth > 0) begin
            top = depth - 1;
            v = frame_v[top];
            j = frame_j[top];
            found = 1'b0;
            // Neighbours at or above the vertex count are never scanned.
            while (!found && j < cnt) begin
              if (graph_rows[v][j] && !seen_mask[j]) found = 1'b1;
              else j++;
            end
            if (found && n < int'(MAX_RESULTS) && depth < int'(VERTEX_CAP)) begin
              frame_j[top] = j + 1;
              seen_mask[j] = 1'b1;
              trail[n] = make_visit(j, graph_labels[j], STATUS_OK, 1'b0);
              n++;
              frame_v[depth] = j;
              frame_j[depth] = 0;
              depth++;
            end else begin
              depth--;
            end
          end
          trail[n-1].last = 1'b1;
          for (int k = 0; k < n; k++) expected_visits.push_back(trail[k]);
        end
      end
      default: begin
        // Unused codes change nothing and owe nothing.
      end
    endcase
  endtask

  // Offers one command item, with a random idle gap in front of it, and
  // feeds the shadow copy once the block has taken it. Valid stays high on
  // return so that a following item can follow without a bubble.
  task automatic send_command(input logic [OP_W-1:0] op, input logic [VIDX_W-1:0] va,
                              input logic [VIDX_W-1:0] vb, input logic [LBL_W-1:0] lab);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.operation <= op;
    in_if.vertex_a  <= va;
    in_if.vertex_b  <= vb;
    in_if.label     <= lab;
    do @(posedge clk); while (!in_if.ready);
    commands_sent++;
    if (op == OP_TRAVERSE) traversals_sent++;
    predict_command(op, va, vb, lab);
  endtask

  // Stops offering commands until every owed visit has come back, then lets
  // the block settle so that it is idle afterwards.
  task automatic wait_for_idle();
    in_if.valid <= 1'b0;
    while (expected_visits.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes the vertex count. Only called after wait_for_idle.
  task automatic write_vertex_count(input logic [VCNT_W-1:0] value);
    cfg_if.valid        <= 1'b1;
    cfg_if.vertex_count <= value;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    count_reg = value;
    config_writes++;
  endtask

  // Index for random stimulus: mostly valid, now and then anything at all so
  // that the range check gets exercised whenever the count is below 16.
  function automatic logic [VIDX_W-1:0] pick_index(input int cnt);
    if ($urandom_range(9) == 0) return VIDX_W'($urandom_range(VIDX_LIMIT - 1));
    return VIDX_W'($urandom_range(cnt - 1));
  endfunction

  // Register values for the random part, extremes included.
  function automatic logic [VCNT_W-1:0] pick_count();
    case ($urandom_range(6))
      0:       return VCNT_W'(0);
      1:       return VCNT_W'(1);
      2:       return VCNT_W'(16);
      3:       return VCNT_W'(31);
      4:       return VCNT_W'($urandom_range(17, 30));
      default: return VCNT_W'($urandom_range(2, 15));
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Test tasks
  // ---------------------------------------------------------------------

  // Straight after reset the graph is empty and all labels are zero, so a
  // traversal reports only its start vertex.
  task automatic test_after_reset();
    send_command(OP_TRAVERSE, 4'd0, 4'd0, 8'd0);
    send_command(OP_TRAVERSE, 4'd15, 4'hf, 8'hff);
  endtask

  // Labels at the field extremes, edges between the lowest and highest
  // vertices, a self loop, a repeated traversal from an already visited
  // start, clearing of the visited marks, and the unused codes.
  task automatic test_labels_edges_unused();
    wait_for_idle();
    write_vertex_count(VCNT_W'(16));
    send_command(OP_SET_LABEL, 4'd0, 4'd0, 8'hff);
    send_command(OP_SET_LABEL, 4'd15, 4'hf, 8'ha5);
    send_command(OP_SET_LABEL, 4'd7, 4'd0, 8'h5a);
    send_command(OP_ADD_EDGE, 4'd0, 4'd15, 8'd0);
    send_command(OP_ADD_EDGE, 4'd15, 4'd7, 8'd0);
    send_command(OP_ADD_EDGE, 4'd7, 4'd7, 8'd0);
    send_command(OP_TRAVERSE, 4'd0, 4'd0, 8'd0);
    send_command(OP_TRAVERSE, 4'd0, 4'd0, 8'd0);
    send_command(OP_CLEAR_VISITED, 4'd0, 4'd0, 8'd0);
    send_command(OP_TRAVERSE, 4'd7, 4'd0, 8'd0);
    send_command(OP_SPARE_LO, 4'hf, 4'hf, 8'hff);
    send_command(OP_SPARE_MID, 4'h0, 4'h0, 8'h00);
    send_command(OP_SPARE_HI, 4'hf, 4'hf, 8'hff);
  endtask

  // A small vertex count: indices at or above it are refused, and edges
  // stored under the larger count are no longer followed. A count of zero
  // behaves like one.
  task automatic test_range_and_leftovers();
    wait_for_idle();
    write_vertex_count(VCNT_W'(4));
    send_command(OP_SET_LABEL, 4'd4, 4'd0, 8'h11);
    send_command(OP_ADD_EDGE, 4'd2, 4'd9, 8'd0);
    send_command(OP_ADD_EDGE, 4'd9, 4'd2, 8'd0);
    send_command(OP_TRAVERSE, 4'd5, 4'd0, 8'd0);
    send_command(OP_TRAVERSE, 4'd0, 4'd0, 8'd0);
    wait_for_idle();
    write_vertex_count(VCNT_W'(0));
    send_command(OP_TRAVERSE, 4'd0, 4'd0, 8'd0);
    send_command(OP_TRAVERSE, 4'd1, 4'd0, 8'd0);
    send_command(OP_CLEAR_GRAPH, 4'd0, 4'd0, 8'd0);
  endtask

  // One random sequence. Most are well formed: random labels and edges on a
  // fresh graph or the last one, then traversals. A path through all vertices
  // in random order drives a traversal to the full visit count. The rest is
  // noise: any code, any index, any label.
  task automatic send_random_sequence();
    int cnt;
    int kind;
    int tmp;
    int swap_at;
    int perm [VIDX_LIMIT];
    cnt = limit_count(count_reg);
    kind = $urandom_range(9);
    if (kind < 2) begin
      repeat ($urandom_range(1, 3))
        send_command(OP_W'($urandom_range(7)), VIDX_W'($urandom_range(15)),
                     VIDX_W'($urandom_range(15)), LBL_W'($urandom_range(255)));
    end else if (kind < 5) begin
      for (int i = 0; i < cnt; i++) perm[i] = i;
      for (int i = cnt - 1; i > 0; i--) begin
        swap_at = $urandom_range(i);
        tmp = perm[i];
        perm[i] = perm[swap_at];
        perm[swap_at] = tmp;
      end
      send_command(OP_CLEAR_GRAPH, VIDX_W'($urandom_range(15)), VIDX_W'($urandom_range(15)),
                   LBL_W'($urandom_range(255)));
      send_command(OP_SET_LABEL, VIDX_W'(perm[0]), VIDX_W'($urandom_range(15)),
                   LBL_W'($urandom_range(255)));
      for (int i = 0; i + 1 < cnt; i++)
        send_command(OP_ADD_EDGE, VIDX_W'(perm[i]), VIDX_W'(perm[i+1]),
                     LBL_W'($urandom_range(255)));
      send_command(OP_TRAVERSE, VIDX_W'(perm[$urandom_range(cnt - 1)]),
                   VIDX_W'($urandom_range(15)), LBL_W'($urandom_range(255)));
    end else begin
      case ($urandom_range(2))
        0: send_command(OP_CLEAR_GRAPH, 4'd0, 4'd0, 8'd0);
        1: send_command(OP_CLEAR_VISITED, VIDX_W'($urandom_range(15)),
                        VIDX_W'($urandom_range(15)), LBL_W'($urandom_range(255)));
        default: begin
          // Keep building on the graph left by the previous sequence.
        end
      endcase
      repeat ($urandom_range(1, 4))
        send_command(OP_SET_LABEL, pick_index(cnt), VIDX_W'($urandom_range(15)),
                     LBL_W'($urandom_range(255)));
      repeat ($urandom_range(1, cnt))
        send_command(OP_ADD_EDGE, pick_index(cnt), pick_index(cnt),
                     LBL_W'($urandom_range(255)));
      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(1) == 0) send_command(OP_CLEAR_VISITED, 4'd0, 4'd0, 8'd0);
        send_command(OP_TRAVERSE, pick_index(cnt), VIDX_W'($urandom_range(15)),
                     LBL_W'($urandom_range(255)));
      end
    end
  endtask

  // Random sequences at the given idle rates, with a new vertex count about
  // every 25 commands.
  task automatic test_random(input int n_items, input int src_pct, input int snk_pct);
    int stop_at;
    int next_config;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    stop_at = commands_sent + n_items;
    next_config = commands_sent;
    while (commands_sent < stop_at) begin
      if (commands_sent >= next_config) begin
        wait_for_idle();
        write_vertex_count(pick_count());
        next_config = commands_sent + 25;
      end
      send_random_sequence();
    end
  endtask

  // The result side stalls for a long stretch while commands keep coming,
  // so the output register fills and the input channel must stall. Then the
  // command side waits until every owed visit has arrived.
  task automatic test_backpressure();
    wait_for_idle();
    write_vertex_count(VCNT_W'(31));
    src_idle_pct = 0;
    snk_idle_pct = 0;
    hold_request = HOLD_CYCLES;
    repeat (3) send_random_sequence();
    wait_for_idle();
  endtask

  // ---------------------------------------------------------------------
  // Result side: ready with random stalls, plus a long stall on request.
  // ---------------------------------------------------------------------
  int hold_left;

  always @(posedge clk) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      out_if.ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_if.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // ---------------------------------------------------------------------
  // Result checking against the oldest owed visit.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    visit_t got;
    visit_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      got = make_visit(int'(out_if.visit_index), out_if.visit_label, out_if.status,
                       out_if.last);
      if (expected_visits.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected item: index %0d label %02h status %0b last %0b",
                   got.idx, got.lbl, got.status, got.last);
        mismatches++;
      end else begin
        want = expected_visits.pop_front();
        visits_checked++;
        if (got.idx !== want.idx || got.lbl !== want.lbl ||
            got.status !== want.status || got.last !== want.last) begin
          if (mismatches < 10)
            $display("mismatch: expected index %0d label %02h status %0b last %0b,",
                     want.idx, want.lbl, want.status, want.last,
                     " got index %0d label %02h status %0b last %0b",
                     got.idx, got.lbl, got.status, got.last);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Watchdog: the run is hung if no channel moves an item for too long.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("no handshake for %0d cycles, %0d visits still owed",
                 idle_cycles, expected_visits.size());
        $display("FAIL adjacency_matrix_dfs_top");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------
  initial begin
    // Shadow copy starts at the reset state of the block.
    for (int r = 0; r < int'(VIDX_LIMIT); r++) begin
      graph_rows[r]   = '0;
      graph_labels[r] = '0;
    end
    seen_mask         = '0;
    count_reg         = VCOUNT_RESET;
    src_idle_pct      = 7;
    snk_idle_pct      = 46;
    hold_request      = 0;
    hold_left         = 0;
    mismatches        = 0;
    commands_sent     = 0;
    traversals_sent   = 0;
    visits_checked    = 0;
    config_writes     = 0;
    idle_cycles       = 0;

    // All block inputs are known from time zero.
    rst_n               = 1'b0;
    in_if.valid         = 1'b0;
    in_if.operation     = OP_SET_LABEL;
    in_if.vertex_a      = '0;
    in_if.vertex_b      = '0;
    in_if.label         = '0;
    out_if.ready        = 1'b0;
    cfg_if.valid        = 1'b0;
    cfg_if.vertex_count = VCOUNT_RESET;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part with the command side seldom idle and the result side
    // often stalling.
    test_after_reset();
    test_labels_edges_unused();
    test_range_and_leftovers();

    // Random part: first the command side idles rarely and the result side
    // often, then the other way round, then neither idles.
    test_random(30, 7, 46);
    test_random(30, 46, 7);
    test_backpressure();
    test_random(30, 0, 0);

    wait_for_idle();

    $display("ran %0d commands (%0d traversals) over %0d vertex-count writes",
             commands_sent, traversals_sent, config_writes);
    $display("checked %0d result items, %0d mismatches", visits_checked, mismatches);
    if (mismatches == 0 && expected_visits.size() == 0) begin
      $display("PASS adjacency_matrix_dfs_top");
    end else begin
      $display("FAIL adjacency_matrix_dfs_top");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: files.f
rtl/adm_pkg.sv
rtl/adm_in_if.sv
rtl/adm_out_if.sv
rtl/adm_cfg_if.sv
rtl/adm_graph_store.sv
rtl/adm_frame_stack.sv
rtl/adm_ctrl.sv
rtl/adjacency_matrix_dfs_top.sv
tb/testbench.sv
